// File: rtl/lr_pkg.sv
// Shared definitions for the line rasterizer.
// Holds operation codes, register addresses, reset values and the canvas type.
// No dependencies.
package lr_pkg;

   localparam int CANVAS_BITS = 11;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   localparam logic REG_CANVAS_WIDTH = 1'b0;
   localparam logic REG_CANVAS_HEIGHT = 1'b1;

   localparam logic [CANVAS_BITS-1:0] CANVAS_RESET = 11'd800;

   typedef struct packed {
      logic [CANVAS_BITS-1:0] width;
      logic [CANVAS_BITS-1:0] height;
   } canvas_type;

endpackage

// File: rtl/line_rasterizer_top.sv
// Top level of the Bresenham line rasterizer.
// Holds the canvas registers and connects front end, queue and pixel walker.
// Depends on lr_pkg, lr_front, lr_queue and lr_back.
//
// Usage:
// The request stream carries one command per transfer. req_tuser is the
// operation: load takes the two endpoints in req_tdata and emits the first
// pixel, advance emits the next pixel of the active line. Every request gives
// exactly one response transfer. rsp_tdata holds the pixel, rsp_tuser[0]
// says a pixel was produced, rsp_tuser[1] says it lies inside the canvas,
// and rsp_tlast marks the exact endpoint of the line.
// The canvas size is written through the CSR port; the user must do so only
// while the block is idle, since the block itself does not enforce this. An
// accepted request is written into the queue and then popped into the response
// register. One request is accepted and one response is produced per cycle
// while the receiver does not stall; the rate is set by the pixel walker, whose
// step is combinational. When the receiver stalls, the response register holds
// and the two-entry queue fills, after which req_tready drops until responses
// drain. Reset clears the active line, empties the queue and sets both canvas
// registers to 800.
module line_rasterizer_top #(
   parameter int COORD_BITS = 12,
   localparam int IN_W = ((4 * COORD_BITS + 7) / 8) * 8,
   localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // start_x, start_y, end_x, end_y
   input  logic [IN_W-1:0]                   req_tdata,
   // operation
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pixel_x, pixel_y
   output logic [OUT_W-1:0]                  rsp_tdata,
   // valid_res, inside_res
   output logic [1:0]                        rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lr_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [lr_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [lr_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import lr_pkg::*;

   localparam int ENTRY_W = 7 * COORD_BITS + 8;

   canvas_type canvas_ff;
   logic csr_write;
   logic queue_full, queue_empty, queue_push, queue_pop;
   logic [ENTRY_W-1:0] push_entry, pop_entry;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_ff.width <= CANVAS_RESET;
         canvas_ff.height <= CANVAS_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_CANVAS_WIDTH: begin
               canvas_ff.width <= csr_pwdata[CANVAS_BITS-1:0];
            end
            REG_CANVAS_HEIGHT: begin
               canvas_ff.height <= csr_pwdata[CANVAS_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_CANVAS_HEIGHT)
      ? CSR_DATA_BITS'(canvas_ff.height) : CSR_DATA_BITS'(canvas_ff.width);

   lr_front #(.COORD_BITS(COORD_BITS)) u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_entry (push_entry)
   );

   lr_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_entry),
      .pop       (queue_pop),
      .pop_data  (pop_entry),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   lr_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .canvas      (canvas_ff),
      .queue_empty (queue_empty),
      .queue_entry (pop_entry),
      .queue_pop   (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// File: rtl/lr_front.sv
// Front end of the line rasterizer: accepts request transfers and classifies them.
// A load is turned into axis, direction, deltas and initial decision value.
// Depends on lr_pkg.
module lr_front #(
   parameter int COORD_BITS = 12,
   localparam int IN_W = ((4 * COORD_BITS + 7) / 8) * 8,
   localparam int ENTRY_W = 7 * COORD_BITS + 8
) (
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [IN_W-1:0]    req_tdata,
   input  logic               req_tuser,
   input  logic               queue_full,
   output logic               queue_push,
   output logic [ENTRY_W-1:0] queue_entry
);
   import lr_pkg::*;

   localparam int C = COORD_BITS;

   typedef struct packed {
      logic                op;
      logic                steep;
      logic                neg;
      logic signed [C-1:0] sx;
      logic signed [C-1:0] sy;
      logic signed [C-1:0] fx;
      logic signed [C-1:0] fy;
      logic [C:0]          maj;
      logic [C:0]          mnr;
      logic signed [C+2:0] dec;
   } entry_type;

   entry_type entry;
   logic signed [C-1:0] in_sx, in_sy, in_ex, in_ey;
   logic signed [C:0] dx, dy, dmin;
   logic [C:0] adx, ady;
   logic swap;

   assign in_sx = req_tdata[C-1:0];
   assign in_sy = req_tdata[2*C-1:C];
   assign in_ex = req_tdata[3*C-1:2*C];
   assign in_ey = req_tdata[4*C-1:3*C];

   always_comb begin
      dx = {in_ex[C-1], in_ex} - {in_sx[C-1], in_sx};
      dy = {in_ey[C-1], in_ey} - {in_sy[C-1], in_sy};
      adx = dx[C] ? (C+1)'(-dx) : (C+1)'(dx);
      ady = dy[C] ? (C+1)'(-dy) : (C+1)'(dy);
      entry.op = req_tuser;
      entry.steep = ady > adx;
      swap = entry.steep ? dy[C] : dx[C];
      dmin = entry.steep ? dx : dy;
      entry.neg = (dmin[C] ^ swap) && (dmin != '0);
      entry.maj = entry.steep ? ady : adx;
      entry.mnr = entry.steep ? adx : ady;
      entry.sx = swap ? in_ex : in_sx;
      entry.sy = swap ? in_ey : in_sy;
      entry.fx = swap ? in_sx : in_ex;
      entry.fy = swap ? in_sy : in_ey;
      entry.dec = $signed({1'b0, entry.mnr, 1'b0}) - $signed({2'b00, entry.maj});
   end

   assign req_tready = !queue_full;
   assign queue_push = req_tvalid && !queue_full;
   assign queue_entry = entry;

endmodule

// File: rtl/lr_queue.sv
// Short queue between the front end and the pixel walker.
// Register based, one push and one pop per cycle. No dependencies.
module lr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty = count_ff == '0;
   assign full = count_ff == CNT_W'(DEPTH);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue push while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("queue pop while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("queue count overflow");

endmodule

// File: rtl/lr_back.sv
// Back end of the line rasterizer: walks the active line one pixel per command.
// Holds the line state and the registered response stage. Depends on lr_pkg.
module lr_back #(
   parameter int COORD_BITS = 12,
   localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8,
   localparam int ENTRY_W = 7 * COORD_BITS + 8
) (
   input  logic               clock,
   input  logic               reset,
   input  lr_pkg::canvas_type canvas,
   input  logic               queue_empty,
   input  logic [ENTRY_W-1:0] queue_entry,
   output logic               queue_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [OUT_W-1:0]   rsp_tdata,
   output logic [1:0]         rsp_tuser,
   output logic               rsp_tlast
);
   import lr_pkg::*;

   localparam int C = COORD_BITS;
   localparam int CW = (C > CANVAS_BITS) ? C : CANVAS_BITS;

   typedef struct packed {
      logic                op;
      logic                steep;
      logic                neg;
      logic signed [C-1:0] sx;
      logic signed [C-1:0] sy;
      logic signed [C-1:0] fx;
      logic signed [C-1:0] fy;
      logic [C:0]          maj;
      logic [C:0]          mnr;
      logic signed [C+2:0] dec;
   } entry_type;

   entry_type cmd;
   logic is_load;

   logic active_ff, active_in;
   logic steep_ff, steep_in;
   logic neg_ff, neg_in;
   logic signed [C-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [C-1:0] fin_x_ff, fin_x_in, fin_y_ff, fin_y_in;
   logic signed [C+2:0] dec_ff, dec_in;
   logic [C:0] maj_ff, maj_in, mnr_ff, mnr_in, rem_ff, rem_in;

   logic out_valid_ff;
   logic [OUT_W-1:0] out_data_ff, out_data_in;
   logic [1:0] out_user_ff, out_user_in;
   logic out_last_ff, out_last_in;

   logic signed [C-1:0] px, py, step;
   logic pix_valid, pix_inside, pix_last, dec_pos;

   assign cmd = queue_entry;
   assign is_load = cmd.op == OP_LOAD;
   assign queue_pop = !queue_empty && (!out_valid_ff || rsp_tready);

   always_comb begin
      active_in = is_load || active_ff;
      steep_in = is_load ? cmd.steep : steep_ff;
      neg_in = is_load ? cmd.neg : neg_ff;
      cur_x_in = is_load ? cmd.sx : cur_x_ff;
      cur_y_in = is_load ? cmd.sy : cur_y_ff;
      fin_x_in = is_load ? cmd.fx : fin_x_ff;
      fin_y_in = is_load ? cmd.fy : fin_y_ff;
      maj_in = is_load ? cmd.maj : maj_ff;
      mnr_in = is_load ? cmd.mnr : mnr_ff;
      dec_in = is_load ? cmd.dec : dec_ff;
      rem_in = is_load ? cmd.maj : rem_ff;
      step = neg_in ? -C'(1) : C'(1);
      dec_pos = !dec_in[C+2] && (dec_in != '0);
      px = '0;
      py = '0;
      pix_valid = 1'b0;
      pix_last = 1'b0;
      if (!active_in) begin
         pix_valid = 1'b0;
      end else if (rem_in == '0) begin
         pix_valid = 1'b1;
         pix_last = 1'b1;
         px = fin_x_in;
         py = fin_y_in;
         active_in = 1'b0;
      end else begin
         pix_valid = 1'b1;
         px = cur_x_in;
         py = cur_y_in;
         if (dec_pos) begin
            if (steep_in) begin
               cur_x_in = cur_x_in + step;
            end else begin
               cur_y_in = cur_y_in + step;
            end
            dec_in = dec_in + $signed({1'b0, mnr_in, 1'b0}) - $signed({1'b0, maj_in, 1'b0});
         end else begin
            dec_in = dec_in + $signed({1'b0, mnr_in, 1'b0});
         end
         if (steep_in) begin
            cur_y_in = cur_y_in + C'(1);
         end else begin
            cur_x_in = cur_x_in + C'(1);
         end
         rem_in = rem_in - 1'b1;
      end
      pix_inside = pix_valid && !px[C-1] && !py[C-1]
         && (CW'(unsigned'(px)) < CW'(canvas.width))
         && (CW'(unsigned'(py)) < CW'(canvas.height));
      out_data_in = '0;
      out_data_in[2*C-1:0] = {py, px};
      out_user_in = {pix_inside, pix_valid};
      out_last_in = pix_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (queue_pop) begin
            active_ff <= active_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         steep_ff <= steep_in;
         neg_ff <= neg_in;
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         fin_x_ff <= fin_x_in;
         fin_y_ff <= fin_y_in;
         maj_ff <= maj_in;
         mnr_ff <= mnr_in;
         dec_ff <= dec_in;
         rem_ff <= rem_in;
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_user_ff;
   assign rsp_tlast = out_last_ff;

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      queue_pop && pix_last |=> !active_ff) else $error("line still active after last");
   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_last_ff |-> out_user_ff[0]) else $error("last without pixel");
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_user_ff[0] |-> (out_data_ff == '0) && !out_last_ff
      && !out_user_ff[1]) else $error("no-pixel response carries data");

endmodule

// File: tb/pixel_checker.sv
`timescale 1ns / 1ps
// Pixel checker for the line rasterizer testbench: mirrors the canvas registers from the
// CSR port, predicts each response from the accepted requests and compares it on the
// response stream. Depends on lr_pkg.
module pixel_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [47:0]                       req_tdata,
   input  logic                              req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [23:0]                       rsp_tdata,
   input  logic [1:0]                        rsp_tuser,
   input  logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lr_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [lr_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input  logic                              csr_pready,
   output int                                mismatches,
   output int                                pending,
   output int                                responses
);
   import lr_pkg::*;

   typedef struct packed {
      logic               valid;
      logic signed [11:0] x;
      logic signed [11:0] y;
      logic               in_canvas;
      logic               last;
   } pixel_type;

   pixel_type expected_pixels[$];

   logic [CANVAS_BITS-1:0] canvas_w;
   logic [CANVAS_BITS-1:0] canvas_h;
   bit line_live;
   bit steep;
   bit minor_neg;
   int cur_x;
   int cur_y;
   int decision;
   int major_len;
   int minor_len;
   int steps_left;
   int stop_x;
   int stop_y;

   function automatic pixel_type plot(input int x, input int y, input bit is_last);
      pixel_type p;
      p.valid = 1'b1;
      p.x = 12'(x);
      p.y = 12'(y);
      p.in_canvas = x >= 0 && y >= 0 && x < int'(canvas_w) && y < int'(canvas_h);
      p.last = is_last;
      return p;
   endfunction

   // Emit the current pixel, then take one step along the major axis.
   function automatic pixel_type walk_pixel();
      pixel_type p;
      int step;
      step = minor_neg ? -1 : 1;
      p = plot(cur_x, cur_y, 1'b0);
      if (decision > 0) begin
         if (steep) cur_x += step;
         else cur_y += step;
         decision += 2 * (minor_len - major_len);
      end else begin
         decision += 2 * minor_len;
      end
      if (steep) cur_y += 1;
      else cur_x += 1;
      steps_left -= 1;
      return p;
   endfunction

   function automatic pixel_type rasterize_step(input logic op, input logic [47:0] coords);
      pixel_type p;
      int sx, sy, ex, ey, t, dx, dy, major, minor;
      if (op == OP_LOAD) begin
         sx = $signed(coords[11:0]);
         sy = $signed(coords[23:12]);
         ex = $signed(coords[35:24]);
         ey = $signed(coords[47:36]);
         dx = ex - sx;
         dy = ey - sy;
         steep = (dy < 0 ? -dy : dy) > (dx < 0 ? -dx : dx);
         if (steep ? (ey < sy) : (ex < sx)) begin
            t = sx; sx = ex; ex = t;
            t = sy; sy = ey; ey = t;
         end
         major = steep ? ey - sy : ex - sx;
         minor = steep ? ex - sx : ey - sy;
         minor_neg = minor < 0;
         if (minor < 0) minor = -minor;
         major_len = major;
         minor_len = minor;
         decision = 2 * minor - major;
         cur_x = sx;
         cur_y = sy;
         stop_x = ex;
         stop_y = ey;
         steps_left = major;
         if (steps_left == 0) begin
            line_live = 1'b0;
            p = plot(stop_x, stop_y, 1'b1);
         end else begin
            line_live = 1'b1;
            p = walk_pixel();
         end
      end else if (!line_live) begin
         p = '0;
      end else if (steps_left == 0) begin
         line_live = 1'b0;
         p = plot(stop_x, stop_y, 1'b1);
      end else begin
         p = walk_pixel();
      end
      return p;
   endfunction

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%t pixel error: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : monitor
      pixel_type want;
      pixel_type got;
      if (reset) begin
         canvas_w = CANVAS_RESET;
         canvas_h = CANVAS_RESET;
         line_live = 1'b0;
         steep = 1'b0;
         minor_neg = 1'b0;
         cur_x = 0;
         cur_y = 0;
         decision = 0;
         major_len = 0;
         minor_len = 0;
         steps_left = 0;
         stop_x = 0;
         stop_y = 0;
         expected_pixels.delete();
         mismatches = 0;
         pending = 0;
         responses = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == {REG_CANVAS_WIDTH, 2'b00}) canvas_w = csr_pwdata[CANVAS_BITS-1:0];
            else if (csr_paddr == {REG_CANVAS_HEIGHT, 2'b00})
               canvas_h = csr_pwdata[CANVAS_BITS-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            responses++;
            got.valid = rsp_tuser[0];
            got.x = rsp_tdata[11:0];
            got.y = rsp_tdata[23:12];
            got.in_canvas = rsp_tuser[1];
            got.last = rsp_tlast;
            if (expected_pixels.size() == 0) begin
               report($sformatf("unexpected response valid=%0b x=%0d y=%0d inside=%0b last=%0b",
                  got.valid, got.x, got.y, got.in_canvas, got.last));
            end else begin
               want = expected_pixels.pop_front();
               if (got.valid !== want.valid || got.x !== want.x || got.y !== want.y ||
                   got.in_canvas !== want.in_canvas || got.last !== want.last)
                  report($sformatf("expected valid=%0b x=%0d y=%0d inside=%0b last=%0b, %s",
                     want.valid, want.x, want.y, want.in_canvas, want.last,
                     $sformatf("got valid=%0b x=%0d y=%0d inside=%0b last=%0b",
                        got.valid, got.x, got.y, got.in_canvas, got.last)));
            end
         end
         if (req_tvalid && req_tready)
            expected_pixels.push_back(rasterize_step(req_tuser, req_tdata));
         pending = expected_pixels.size();
      end
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the line rasterizer testbench: drives requests in bursts, stalls the response
// stream, reprograms the canvas between phases and gives the verdict.
// Depends on lr_pkg, line_rasterizer_top and pixel_checker.
module testbench;
   import lr_pkg::*;

   localparam int COORD_MAX = 2047;
   localparam int COORD_MIN = -2048;

   typedef enum int {STALL_NONE, STALL_HALF, STALL_LIGHT, STALL_HEAVY} stall_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic req_tuser = OP_LOAD;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   int mismatches;
   int pending;
   int responses;
   int loads_sent = 0;
   int advances_sent = 0;
   int settings_used = 1;
   int burst_left = 0;
   int canvas_w_now = CANVAS_RESET;
   int canvas_h_now = CANVAS_RESET;
   stall_type stall_mode = STALL_NONE;
   int stall_left = 0;

   line_rasterizer_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   pixel_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .mismatches(mismatches), .pending(pending), .responses(responses)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver switches between randomly chosen stall patterns.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 120);
      end else begin
         stall_left = stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE: rsp_tready <= 1'b1;
         STALL_HALF: rsp_tready <= 1'($urandom_range(0, 1));
         STALL_LIGHT: rsp_tready <= ($urandom_range(0, 7) != 0);
         default: rsp_tready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   function automatic logic [47:0] random_word48();
      return {16'($urandom()), $urandom()};
   endfunction

   function automatic logic [47:0] pack_endpoints(input int sx, input int sy, input int ex,
                                                  input int ey);
      return {12'(ey), 12'(ex), 12'(sy), 12'(sx)};
   endfunction

   function automatic int random_coord(input int limit);
      int v;
      if ($urandom_range(0, 1)) begin
         v = int'($urandom_range(0, limit + 8)) - 4;
         if (v > COORD_MAX) v = COORD_MAX;
      end else begin
         v = int'($urandom_range(0, 4095)) + COORD_MIN;
      end
      return v;
   endfunction

   function automatic int offset_coord(input int base, input int delta);
      if (base + delta > COORD_MAX || base + delta < COORD_MIN) return base - delta;
      return base + delta;
   endfunction

   task automatic send_command(input logic op, input logic [47:0] coords);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            req_tdata <= random_word48();
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= coords;
      do @(posedge clock); while (!req_tready);
      if (op == OP_LOAD) loads_sent++;
      else advances_sent++;
   endtask

   task automatic load_line(input int sx, input int sy, input int ex, input int ey);
      send_command(OP_LOAD, pack_endpoints(sx, sy, ex, ey));
   endtask

   task automatic advance(input int count);
      repeat (count) send_command(OP_ADVANCE, random_word48());
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_csr(input logic reg_index, input int value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_index, 2'b00};
      csr_pwdata <= CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic apply_canvas(input int w, input int h);
      settle();
      write_csr(REG_CANVAS_WIDTH, w);
      write_csr(REG_CANVAS_HEIGHT, h);
      canvas_w_now = w;
      canvas_h_now = h;
      settings_used++;
   endtask

   // Mostly complete lines; some are cut short by the next load, some run past their end.
   task automatic draw_random_line();
      int pick, span_major, span_minor, sx, sy, dx, dy, steps;
      pick = $urandom_range(0, 99);
      if (pick < 80) span_major = $urandom_range(0, 15);
      else if (pick < 96) span_major = $urandom_range(16, 80);
      else span_major = $urandom_range(81, 250);
      span_minor = ($urandom_range(0, 3) == 0) ? span_major : $urandom_range(0, span_major);
      sx = random_coord(canvas_w_now);
      sy = random_coord(canvas_h_now);
      if ($urandom_range(0, 1)) begin
         dx = span_minor;
         dy = span_major;
      end else begin
         dx = span_major;
         dy = span_minor;
      end
      if ($urandom_range(0, 1)) dx = -dx;
      if ($urandom_range(0, 1)) dy = -dy;
      load_line(sx, sy, offset_coord(sx, dx), offset_coord(sy, dy));
      pick = $urandom_range(0, 99);
      if (pick < 10) steps = $urandom_range(0, span_major);
      else if (pick < 20) steps = span_major + $urandom_range(1, 3);
      else steps = span_major;
      advance(steps);
   endtask

   task automatic run_random(input int target);
      int first;
      first = loads_sent + advances_sent;
      while (loads_sent + advances_sent - first < target) begin
         if ($urandom_range(0, 99) < 6)
            send_command($urandom_range(0, 1) ? OP_ADVANCE : OP_LOAD, random_word48());
         else
            draw_random_line();
      end
   endtask

   initial begin
      #5000000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset canvas size.
      advance(1);
      load_line(5, 5, 5, 5);
      advance(1);
      load_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      advance(2);
      load_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
      advance(1);
      load_line(3, 4, 1, 0);
      advance(5);
      load_line(0, 2, 4, 0);
      advance(4);
      load_line(799, 799, 801, 799);
      advance(2);
      load_line(-1, -1, 0, 0);
      advance(1);

      run_random(140);
      apply_canvas(2047, 2047);
      run_random(140);
      apply_canvas(1, 1);
      run_random(140);
      apply_canvas(0, 0);
      run_random(100);
      apply_canvas($urandom_range(1, 2047), $urandom_range(1, 2047));
      run_random(140);
      apply_canvas($urandom_range(1, 64), $urandom_range(1, 64));
      run_random(140);

      settle();
      repeat (10) @(negedge clock);
      $display("Run covered %0d loads and %0d advances over %0d canvas settings.",
         loads_sent, advances_sent, settings_used);
      $display("%0d pixel responses were checked under random sender gaps and receiver stalls.",
         responses);
      if (mismatches == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
